// ----- src/plist_pkg.sv -----
//------------------------------------------------------------------------------
// plist_pkg
// Field widths, operation and status codes, and controller states shared by
// the positional list engine.
//------------------------------------------------------------------------------
`default_nettype none

package plist_pkg;

	localparam int ACTION_W  = 3;
	localparam int VALUE_W   = 32;
	localparam int POS_W     = 7;
	localparam int STATUS_W  = 3;
	localparam int FOUND_W   = 6;
	localparam int COUNT_W   = 7;

	localparam int S_TDATA_W = 40;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 48;
	localparam int M_TUSER_W = 3;

	typedef enum logic [ACTION_W-1:0] {
		ACT_INS_FRONT = 3'd0,
		ACT_INS_BACK  = 3'd1,
		ACT_INS_AT    = 3'd2,
		ACT_DEL_FRONT = 3'd3,
		ACT_DEL_BACK  = 3'd4,
		ACT_DEL_AT    = 3'd5,
		ACT_SEARCH    = 3'd6,
		ACT_NOP       = 3'd7
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 3'd0,
		STAT_FULL     = 3'd1,
		STAT_EMPTY    = 3'd2,
		STAT_BADPOS   = 3'd3,
		STAT_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DCAP,
		S_SHIFT,
		S_PUT,
		S_SRCH,
		S_FIN
	} state_t;

endpackage

`default_nettype wire

// ----- src/positional_list_engine.sv -----
//------------------------------------------------------------------------------
// positional_list_engine
// Ordered list of up to CAPACITY words with insert and delete by position and
// search by value, kept as a ring in a single simple dual-port memory.
//------------------------------------------------------------------------------
// The list lives in a ring buffer with a head pointer, so front and back
// inserts and deletes touch one entry. Insert at position i moves count-i
// entries; delete at position i moves count-1-i entries; search reads
// entries in order. Moves are bounded by the memory, which reads one entry
// and writes one per cycle. One item is worked at a time; the next item is
// accepted as soon as the previous result sits in the output register. No
// clearing pass is needed after reset.
`default_nettype none

module positional_list_engine #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// [31:0] value, [38:32] position, [39] zero
	input  wire logic [plist_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// [2:0] action
	input  wire logic [plist_pkg::S_TUSER_W-1:0] s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// [31:0] removed_value, [37:32] found_index, [44:38] entry_count, [47:45] zero
	output logic      [plist_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// [2:0] status
	output logic      [plist_pkg::M_TUSER_W-1:0] m_axis_tuser
);

	import plist_pkg::*;

	localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

	function automatic logic [ADDR_W-1:0] phys(input logic [CNT_W-1:0] lidx,
		input logic [ADDR_W-1:0] base);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(base) + (CNT_W+1)'(lidx);
		if (sum >= (CNT_W+1)'(CAPACITY)) begin
			sum = sum - (CNT_W+1)'(CAPACITY);
		end
		return sum[ADDR_W-1:0];
	endfunction

	state_t                state_q, state_d;
	logic [CNT_W-1:0]      count_q, count_d;
	logic [ADDR_W-1:0]     head_q, head_d;
	logic                  pend_s1, pend_d;
	logic                  m_valid_q, m_valid_d;

	logic [DATA_WIDTH-1:0] word_q, word_d;
	logic [CNT_W-1:0]      idx_q, idx_d;
	logic [CNT_W-1:0]      cur_q, cur_d;
	logic [CNT_W-1:0]      rem_q, rem_d;
	logic                  dir_q, dir_d;
	logic [ADDR_W-1:0]     pend_dst_s1, pend_dst_d;
	logic [CNT_W-1:0]      pend_idx_s1, pend_idx_d;
	status_t               status_q, status_d;
	logic [VALUE_W-1:0]    removed_q, removed_d;
	logic [ADDR_W-1:0]     found_q, found_d;

	logic [M_TDATA_W-1:0]  m_data_q, m_data_d;
	logic [M_TUSER_W-1:0]  m_user_q, m_user_d;

	logic                  wr_en, rd_en;
	logic [ADDR_W-1:0]     wr_addr, rd_addr;
	logic [DATA_WIDTH-1:0] wr_data, rd_data;

	logic                  accept, out_free;
	action_t               act_in;
	logic [DATA_WIDTH-1:0] word_in;
	logic [CMP_W-1:0]      pos_in, cnt_ext, idx_ext;
	logic [ADDR_W-1:0]     head_dec, head_inc;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;
	assign act_in   = action_t'(s_axis_tuser[ACTION_W-1:0]);
	assign word_in  = DATA_WIDTH'(s_axis_tdata[VALUE_W-1:0]);
	assign pos_in   = CMP_W'(s_axis_tdata[VALUE_W +: POS_W]);
	assign cnt_ext  = CMP_W'(count_q);
	assign head_dec = (head_q == '0) ? ADDR_W'(CAPACITY - 1) : head_q - 1'b1;
	assign head_inc = (head_q == ADDR_W'(CAPACITY - 1)) ? '0 : head_q + 1'b1;

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	plist_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (DATA_WIDTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		head_d     = head_q;
		pend_d     = 1'b0;
		word_d     = word_q;
		idx_d      = idx_q;
		cur_d      = cur_q;
		rem_d      = rem_q;
		dir_d      = dir_q;
		pend_dst_d = pend_dst_s1;
		pend_idx_d = pend_idx_s1;
		status_d   = status_q;
		removed_d  = removed_q;
		found_d    = found_q;
		m_valid_d  = m_valid_q && !m_axis_tready;
		m_data_d   = m_data_q;
		m_user_d   = m_user_q;
		wr_en      = 1'b0;
		wr_addr    = phys(idx_q, head_q);
		wr_data    = word_q;
		rd_en      = 1'b0;
		rd_addr    = phys(cur_q, head_q);
		idx_ext    = '0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					word_d    = word_in;
					status_d  = STAT_OK;
					removed_d = '0;
					found_d   = '0;
					state_d   = S_FIN;
					unique case (act_in)
						ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT: begin
							if (act_in == ACT_INS_FRONT) begin
								idx_ext = '0;
							end else if (act_in == ACT_INS_BACK) begin
								idx_ext = cnt_ext;
							end else begin
								idx_ext = pos_in;
							end
							if (idx_ext > cnt_ext) begin
								status_d = STAT_BADPOS;
							end else if (cnt_ext >= CMP_W'(CAPACITY)) begin
								status_d = STAT_FULL;
							end else if (idx_ext == '0) begin
								head_d  = head_dec;
								wr_en   = 1'b1;
								wr_addr = head_dec;
								wr_data = word_in;
								count_d = count_q + 1'b1;
							end else begin
								idx_d   = CNT_W'(idx_ext);
								rem_d   = count_q - CNT_W'(idx_ext);
								cur_d   = count_q - 1'b1;
								dir_d   = 1'b0;
								state_d = S_SHIFT;
							end
						end
						ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_AT: begin
							if (act_in == ACT_DEL_FRONT) begin
								idx_ext = '0;
							end else if (act_in == ACT_DEL_BACK) begin
								idx_ext = cnt_ext - 1'b1;
							end else begin
								idx_ext = pos_in;
							end
							if (count_q == '0) begin
								status_d = STAT_EMPTY;
							end else if (idx_ext >= cnt_ext) begin
								status_d = STAT_BADPOS;
							end else begin
								idx_d   = CNT_W'(idx_ext);
								rd_en   = 1'b1;
								rd_addr = phys(CNT_W'(idx_ext), head_q);
								state_d = S_DCAP;
							end
						end
						ACT_SEARCH: begin
							if (count_q == '0) begin
								status_d = STAT_NOTFOUND;
							end else begin
								cur_d   = '0;
								rem_d   = count_q;
								state_d = S_SRCH;
							end
						end
						ACT_NOP: begin
						end
					endcase
				end
			end
			S_DCAP: begin
				removed_d = VALUE_W'(rd_data);
				if (idx_q == '0) begin
					head_d  = head_inc;
					count_d = count_q - 1'b1;
					state_d = S_FIN;
				end else begin
					rem_d   = count_q - idx_q - 1'b1;
					cur_d   = idx_q + 1'b1;
					dir_d   = 1'b1;
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				// reads run one entry ahead of the trailing write
				if (rem_q != '0) begin
					rd_en      = 1'b1;
					pend_d     = 1'b1;
					pend_dst_d = dir_q ? phys(cur_q - 1'b1, head_q)
					                   : phys(cur_q + 1'b1, head_q);
					cur_d      = dir_q ? cur_q + 1'b1 : cur_q - 1'b1;
					rem_d      = rem_q - 1'b1;
				end
				if (pend_s1) begin
					wr_en   = 1'b1;
					wr_addr = pend_dst_s1;
					wr_data = rd_data;
				end
				if (rem_q == '0 && !pend_s1) begin
					if (dir_q) begin
						count_d = count_q - 1'b1;
						state_d = S_FIN;
					end else begin
						state_d = S_PUT;
					end
				end
			end
			S_PUT: begin
				wr_en   = 1'b1;
				count_d = count_q + 1'b1;
				state_d = S_FIN;
			end
			S_SRCH: begin
				if (rem_q != '0) begin
					rd_en      = 1'b1;
					pend_d     = 1'b1;
					pend_idx_d = cur_q;
					cur_d      = cur_q + 1'b1;
					rem_d      = rem_q - 1'b1;
				end
				if (pend_s1 && rd_data == word_q) begin
					found_d  = ADDR_W'(pend_idx_s1);
					status_d = STAT_OK;
					pend_d   = 1'b0;
					state_d  = S_FIN;
				end else if (rem_q == '0 && !pend_s1) begin
					status_d = STAT_NOTFOUND;
					state_d  = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					m_valid_d = 1'b1;
					m_data_d  = {(M_TDATA_W - VALUE_W - FOUND_W - COUNT_W)'(0),
						COUNT_W'(count_q), FOUND_W'(found_q), removed_q};
					m_user_d  = M_TUSER_W'(status_q);
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			head_q    <= '0;
			pend_s1   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			head_q    <= head_d;
			pend_s1   <= pend_d;
			m_valid_q <= m_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		word_q      <= word_d;
		idx_q       <= idx_d;
		cur_q       <= cur_d;
		rem_q       <= rem_d;
		dir_q       <= dir_d;
		pend_dst_s1 <= pend_dst_d;
		pend_idx_s1 <= pend_idx_d;
		status_q    <= status_d;
		removed_q   <= removed_d;
		found_q     <= found_d;
		m_data_q    <= m_data_d;
		m_user_q    <= m_user_d;
	end

endmodule

`default_nettype wire

// ----- src/plist_ram.sv -----
//------------------------------------------------------------------------------
// plist_ram
// Simple dual-port element store: one write port, one read port, read data
// registered.
//------------------------------------------------------------------------------
`default_nettype none

module plist_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire
